// ===== hw/rtl/hpsad_pkg.sv =====
// Shared types, constants and codes for the half-pel block SAD engine.
`timescale 1ns / 1ps
package hpsad_pkg;

	localparam int PIX_W        = 8;
	localparam int NUM_PIX      = 16;
	localparam int NUM_REF      = NUM_PIX + 1;
	localparam int LANES        = 16;
	localparam int NARROW_LANES = 8;
	localparam int SAD_W        = 16;
	localparam int ROW_W        = $clog2(NUM_PIX * ((1 << PIX_W) - 1) + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;
	localparam int TDATA_W    = NUM_PIX * PIX_W * 2 + PIX_W + 0; // 264, whole bytes

	typedef logic [PIX_W-1:0]               pix_t;
	typedef logic [NUM_PIX-1:0][PIX_W-1:0]  cur_row_t;
	typedef logic [NUM_REF-1:0][PIX_W-1:0]  ref_row_t;
	typedef logic [NUM_PIX-1:0][PIX_W-1:0]  diff_row_t;
	typedef logic [ROW_W-1:0]               row_sum_t;
	typedef logic [SAD_W-1:0]               sad_t;

	typedef enum logic [1:0] {
		MODE_FULL  = 2'd0,
		MODE_HORIZ = 2'd1,
		MODE_VERT  = 2'd2,
		MODE_DIAG  = 2'd3
	} interp_mode_t;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_INTERP_MODE = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_NARROW      = cfg_idx_t'(1);

	localparam sad_t SAD_MAX = {SAD_W{1'b1}};

endpackage

// ===== hw/rtl/halfpel_block_sad.sv =====
// Top level: row capture, sixteen SAD lanes, merge tree and saturating accumulator.
//
//  channel | direction | handshake            | payload
//  s_*     | in        | s_tvalid / s_tready  | s_tdata rows, s_tuser prime, s_tlast last row
//  m_*     | out       | m_tvalid / m_tready  | m_tdata block SAD
//  cfg_*   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One row is accepted every cycle while s_tready is high; the result of a last row passes the
// capture register, lane register, merge-tree register and output register before it shows on m_*.
// The accumulator add-and-saturate is the only loop.
// Reset clears all valid flags, the accumulator, the previous-row store and config.
// A waiting result holds a last row at the accumulator; the rows behind it back up to s_tready.
`timescale 1ns / 1ps
module halfpel_block_sad (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [63:0] cur_low, [127:64] cur_high, [191:128] ref_low, [255:192] ref_high,
	// [263:256] ref_extra
	input  logic [hpsad_pkg::TDATA_W-1:0]        s_tdata,
	// [0] prime_row
	input  logic                                 s_tuser,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [15:0] sad_total
	output logic [hpsad_pkg::SAD_W-1:0]          m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hpsad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hpsad_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CUR_BITS = hpsad_pkg::NUM_PIX * hpsad_pkg::PIX_W;
	localparam int REF_BITS = hpsad_pkg::NUM_REF * hpsad_pkg::PIX_W;

	hpsad_pkg::interp_mode_t mode_q;
	logic                    narrow_q;
	hpsad_pkg::ref_row_t     prev_q;
	hpsad_pkg::sad_t         acc_q;
	hpsad_pkg::sad_t         out_q;
	logic                    out_valid_q;

	hpsad_pkg::cur_row_t     cur_s1;
	hpsad_pkg::ref_row_t     ref_s1;
	hpsad_pkg::ref_row_t     prv_s1;
	logic                    v_s1, prime_s1, last_s1;

	hpsad_pkg::diff_row_t    diff_s2;
	logic                    v_s2, prime_s2, last_s2;

	hpsad_pkg::row_sum_t     row_s3;
	logic                    v_s3, prime_s3, last_s3;

	hpsad_pkg::diff_row_t    lane_diff;
	hpsad_pkg::row_sum_t     row_sum;
	hpsad_pkg::ref_row_t     in_ref;
	logic                    in_accept, out_free, emit3, adv3, rdy3, rdy2, rdy1;
	logic [hpsad_pkg::SAD_W:0] acc_sum;
	hpsad_pkg::sad_t         acc_sat;

	assign in_ref    = s_tdata[CUR_BITS +: REF_BITS];
	assign cfg_ready = 1'b1;

	// Ready chain: only a last row that is not a priming row at the accumulator waits for the output register.
	always_comb begin
		out_free  = !out_valid_q || m_tready;
		emit3     = v_s3 && last_s3 && !prime_s3;
		adv3      = v_s3 && (!emit3 || out_free);
		rdy3      = !v_s3 || adv3;
		rdy2      = !v_s2 || rdy3;
		rdy1      = !v_s1 || rdy2;
		s_tready  = rdy1;
		in_accept = s_tvalid && rdy1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= hpsad_pkg::MODE_FULL;
			narrow_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				hpsad_pkg::CFG_INTERP_MODE: mode_q   <= hpsad_pkg::interp_mode_t'(cfg_data);
				hpsad_pkg::CFG_NARROW:      narrow_q <= cfg_data[0];
				default:                    ;
			endcase
		end
	end

	// Capture stage: every accepted row also becomes the previous row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= s_tvalid;
			if (in_accept)
				prev_q <= in_ref;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cur_s1   <= s_tdata[CUR_BITS-1:0];
			ref_s1   <= in_ref;
			prv_s1   <= prev_q;
			prime_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	for (genvar g = 0; g < hpsad_pkg::NUM_PIX; g++) begin : g_lane
		hpsad_lane u_lane (
			.mode  (mode_q),
			.ref_a (ref_s1[g]),
			.ref_b (ref_s1[g+1]),
			.prv_c (prv_s1[g]),
			.prv_d (prv_s1[g+1]),
			.cur_x (cur_s1[g]),
			.diff  (lane_diff[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			diff_s2  <= lane_diff;
			prime_s2 <= prime_s1;
			last_s2  <= last_s1;
		end
	end

	hpsad_merge u_merge (
		.diff    (diff_s2),
		.narrow  (narrow_q),
		.row_sum (row_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (rdy3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			row_s3   <= row_sum;
			prime_s3 <= prime_s2;
			last_s3  <= last_s2;
		end
	end

	always_comb begin
		acc_sum = {1'b0, acc_q} + (hpsad_pkg::SAD_W+1)'(row_s3);
		acc_sat = acc_sum[hpsad_pkg::SAD_W] ? hpsad_pkg::SAD_MAX
			: acc_sum[hpsad_pkg::SAD_W-1:0];
	end

	// Accumulate, clear on priming, emit (unless also priming) and clear on the last row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv3) begin
				if (prime_s3 || last_s3)
					acc_q <= '0;
				else
					acc_q <= acc_sat;
			end
			if (adv3 && emit3)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && emit3)
			out_q <= acc_sat;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`ifndef ASSERT_OFF
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(adv3 && emit3))
		else $error("result raised without a last row at the accumulator");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv3 && emit3) |=> acc_q == '0)
		else $error("accumulator not cleared after block result");

	a_clear_on_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(adv3 && prime_s3) |=> acc_q == '0)
		else $error("accumulator not cleared by priming row");

	a_prev_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> prev_q == $past(in_ref))
		else $error("previous reference row not captured");
`endif

endmodule

// ===== hw/rtl/hpsad_lane.sv =====
// One pixel lane: form the interpolated reference pixel and take the absolute difference.
`timescale 1ns / 1ps
module hpsad_lane (
	input  hpsad_pkg::interp_mode_t mode,
	input  hpsad_pkg::pix_t         ref_a,
	input  hpsad_pkg::pix_t         ref_b,
	input  hpsad_pkg::pix_t         prv_c,
	input  hpsad_pkg::pix_t         prv_d,
	input  hpsad_pkg::pix_t         cur_x,
	output hpsad_pkg::pix_t         diff
);

	logic [hpsad_pkg::PIX_W:0]   avg_h;
	logic [hpsad_pkg::PIX_W:0]   avg_v;
	logic [hpsad_pkg::PIX_W+1:0] avg_d;
	hpsad_pkg::pix_t             pred;

	always_comb begin
		avg_h = {1'b0, ref_a} + {1'b0, ref_b} + (hpsad_pkg::PIX_W+1)'(1);
		avg_v = {1'b0, prv_c} + {1'b0, ref_a} + (hpsad_pkg::PIX_W+1)'(1);
		avg_d = {2'b00, ref_a} + {2'b00, ref_b} + {2'b00, prv_c} + {2'b00, prv_d}
			+ (hpsad_pkg::PIX_W+2)'(2);
		case (mode)
			hpsad_pkg::MODE_HORIZ: pred = avg_h[hpsad_pkg::PIX_W:1];
			hpsad_pkg::MODE_VERT:  pred = avg_v[hpsad_pkg::PIX_W:1];
			hpsad_pkg::MODE_DIAG:  pred = avg_d[hpsad_pkg::PIX_W+1:2];
			default:               pred = ref_a;
		endcase
		diff = (cur_x > pred) ? (cur_x - pred) : (pred - cur_x);
	end

endmodule

// ===== hw/rtl/hpsad_merge.sv =====
// Masked adder tree that merges the lane differences into one row sum.
`timescale 1ns / 1ps
module hpsad_merge (
	input  hpsad_pkg::diff_row_t diff,
	input  logic                 narrow,
	output hpsad_pkg::row_sum_t  row_sum
);

	localparam int W = hpsad_pkg::PIX_W;

	logic [7:0][W:0]   lvl1;
	logic [3:0][W+1:0] lvl2;
	logic [1:0][W+2:0] lvl3;
	hpsad_pkg::diff_row_t masked;

	always_comb begin
		for (int i = 0; i < hpsad_pkg::NUM_PIX; i++) begin
			if (i < hpsad_pkg::LANES && (!narrow || i < hpsad_pkg::NARROW_LANES))
				masked[i] = diff[i];
			else
				masked[i] = '0;
		end
		for (int i = 0; i < 8; i++)
			lvl1[i] = {1'b0, masked[2*i]} + {1'b0, masked[2*i+1]};
		for (int i = 0; i < 4; i++)
			lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
		for (int i = 0; i < 2; i++)
			lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
		row_sum = hpsad_pkg::row_sum_t'({1'b0, lvl3[0]} + {1'b0, lvl3[1]});
	end

endmodule
